@@ rtl/mrac_pkg.sv @@
// package: constants, types and arithmetic helpers of the admission control unit
`default_nettype none

package mrac_pkg;

   localparam int SLAB_CLASSES = 8;
   localparam int NDIM         = 10 + SLAB_CLASSES;
   localparam int IDX_W        = $clog2(NDIM);
   localparam int DIM_W        = 5;
   localparam int AMT_W        = 64;
   localparam int CMD_W        = 3;
   localparam int SCOPE_W      = 3;
   localparam int STATUS_W     = 2;

   localparam logic [SCOPE_W-1:0] SCOPE_MAX = SCOPE_W'(6);
   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NDIM - 1);

   typedef logic [AMT_W-1:0] amt_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_STAGE    = 3'd0,
      CMD_RESERVE  = 3'd1,
      CMD_COMMIT   = 3'd2,
      CMD_ROLLBACK = 3'd3,
      CMD_RELEASE  = 3'd4,
      CMD_LOAD     = 3'd5,
      CMD_QUERY    = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_INVALID      = 2'd1,
      ST_EXHAUSTED    = 2'd2,
      ST_INCONSISTENT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SINGLE,
      S_SCAN,
      S_DECIDE,
      S_APPLY,
      S_RESP
   } state_type;

   // budget entry: limit, emergency reserve and staged request
   typedef struct packed {
      amt_type limit;
      amt_type reserve;
      amt_type staged;
   } budget_type;

   // usage entry: committed and pending amounts
   typedef struct packed {
      amt_type committed;
      amt_type pending;
   } usage_type;

   localparam amt_type ALL_ONES = '1;

   function automatic amt_type sat_add(amt_type a, amt_type b);
      logic [AMT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[AMT_W] ? ALL_ONES : sum[AMT_W-1:0];
   endfunction

   function automatic amt_type sat_inc(amt_type v);
      return (v == ALL_ONES) ? v : v + AMT_W'(1);
   endfunction

   // limit less reserve, floored at zero
   function automatic amt_type ceiling(amt_type limit, amt_type res);
      return (limit >= res) ? limit - res : '0;
   endfunction

   // room left under a ceiling for a saturated usage sum
   function automatic amt_type room(amt_type ceil, amt_type used);
      return (used >= ceil) ? '0 : ceil - used;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mrac_if.sv @@
// interfaces: request and response channels of the admission control unit
`default_nettype none

interface mrac_req_if;
   import mrac_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [DIM_W-1:0]     dimension;
   logic [AMT_W-1:0]     amount;
   logic [AMT_W-1:0]     reserve_amount;
   logic                 data_class;
   logic [SCOPE_W-1:0]   scope;

   modport source (output valid, cmd, dimension, amount, reserve_amount, data_class, scope,
                   input ready);
   modport sink   (input valid, cmd, dimension, amount, reserve_amount, data_class, scope,
                   output ready);
endinterface

interface mrac_rsp_if;
   import mrac_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [DIM_W-1:0]     fail_dimension;
   logic [AMT_W-1:0]     requested;
   logic [AMT_W-1:0]     available;
   logic [AMT_W-1:0]     headroom_data;
   logic [AMT_W-1:0]     headroom_control;
   logic [AMT_W-1:0]     committed_value;
   logic [AMT_W-1:0]     pending_value;
   logic [AMT_W-1:0]     accepted_count;
   logic [AMT_W-1:0]     rejected_count;
   logic [AMT_W-1:0]     event_count;

   modport source (output valid, status, fail_dimension, requested, available, headroom_data,
                   headroom_control, committed_value, pending_value, accepted_count,
                   rejected_count, event_count,
                   input ready);
   modport sink   (input valid, status, fail_dimension, requested, available, headroom_data,
                   headroom_control, committed_value, pending_value, accepted_count,
                   rejected_count, event_count,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/mrac_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module mrac_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 18
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/multi_resource_admission_control_unit.sv @@
// top level: multi-resource admission control with budget and usage tables in ram
//
//  channel   role    direction  accepted when
//  req_chan  sink    in         req_chan.valid & req_chan.ready
//  rsp_chan  source  out        rsp_chan.valid & rsp_chan.ready
//
// stage, load and query step through read, update and respond states (an out-of-range
// dimension goes straight to respond). reserve, commit, rollback and release step through a
// check walk over both rams, a decide state, a read-modify-write walk of the usage ram and
// the response load. an invalid or failed request skips the second walk, and the next
// transaction can be accepted in the cycle after the load.
// reset is synchronous; all table entries read as zero until written (per-entry valid bits).
// a new transaction is accepted while the previous response still waits in its register;
// a full response register holds the block in its respond state and stalls the input.
`default_nettype none

module multi_resource_admission_control_unit (
   input wire logic clock,
   input wire logic reset,
   mrac_req_if.sink   req_chan,
   mrac_rsp_if.source rsp_chan
);
   import mrac_pkg::*;

   state_type              state_ff, state_in;

   // latched transaction
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [DIM_W-1:0]       dim_ff, dim_in;
   amt_type                amount_ff, amount_in;
   amt_type                resv_ff, resv_in;
   logic                   data_ff, data_in;
   logic [SCOPE_W-1:0]     scope_ff, scope_in;

   // result work registers
   status_type             status_ff, status_in;
   logic                   any_ff, any_in;
   logic                   fail_seen_ff, fail_seen_in;
   logic [IDX_W-1:0]       fail_idx_ff, fail_idx_in;
   amt_type                fail_req_ff, fail_req_in;
   amt_type                fail_av_ff, fail_av_in;
   amt_type                hd_ff, hd_in, hc_ff, hc_in, qc_ff, qc_in, qp_ff, qp_in;

   // walk pipeline
   logic [IDX_W-1:0]       issue_idx_ff, issue_idx_in;
   logic                   issue_done_ff, issue_done_in;
   logic                   rd_v_ff, rd_v_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   e_v_ff, e_v_in;
   logic [IDX_W-1:0]       e_idx_ff, e_idx_in;
   amt_type                e_s_ff, e_s_in, e_ceil_ff, e_ceil_in, e_used_ff, e_used_in;
   logic                   e_cmp_ff, e_cmp_in;

   // table valid bits
   logic [NDIM-1:0]        bud_vld_ff, bud_vld_in, use_vld_ff, use_vld_in;
   logic                   bud_rv_ff, bud_rv_in, use_rv_ff, use_rv_in;

   // counters
   amt_type                acc_ff, acc_in, rej_ff, rej_in, seq_ff, seq_in;

   // response register
   logic                   rsp_v_ff, rsp_v_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [DIM_W-1:0]       rsp_fdim_ff, rsp_fdim_in;
   amt_type                rsp_req_ff, rsp_req_in, rsp_av_ff, rsp_av_in;
   amt_type                rsp_hd_ff, rsp_hd_in, rsp_hc_ff, rsp_hc_in;
   amt_type                rsp_qc_ff, rsp_qc_in, rsp_qp_ff, rsp_qp_in;
   amt_type                rsp_acc_ff, rsp_acc_in, rsp_rej_ff, rsp_rej_in;
   amt_type                rsp_seq_ff, rsp_seq_in;

   // ram ports
   logic                   bud_we, use_we;
   logic [IDX_W-1:0]       bud_waddr, use_waddr, ram_raddr;
   budget_type             bud_wdata, bud_q, bud_rd;
   usage_type              use_wdata, use_q, use_rd;

   logic                   accept, req_dim_ok, dim_ok, rsp_free;
   logic                   scan_last, apply_last, go_apply, cur_fail;
   logic [IDX_W-1:0]       dim_idx;
   amt_type                cur_av, bud_ceil;

   mrac_ram #(.WIDTH($bits(budget_type)), .DEPTH(NDIM)) u_bud_ram (
      .clock (clock),
      .we    (bud_we),
      .waddr (bud_waddr),
      .wdata (bud_wdata),
      .raddr (ram_raddr),
      .rdata (bud_q)
   );

   mrac_ram #(.WIDTH($bits(usage_type)), .DEPTH(NDIM)) u_use_ram (
      .clock (clock),
      .we    (use_we),
      .waddr (use_waddr),
      .wdata (use_wdata),
      .raddr (ram_raddr),
      .rdata (use_q)
   );

   // handshake and common decode
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_v_ff || rsp_chan.ready;
   assign req_dim_ok     = int'(req_chan.dimension) < NDIM;
   assign dim_ok         = int'(dim_ff) < NDIM;
   assign dim_idx        = IDX_W'(dim_ff);
   assign ram_raddr      = (state_ff == S_READ) ? dim_idx : issue_idx_ff;

   // entries never written read as zero
   assign bud_rd = bud_rv_ff ? bud_q : '0;
   assign use_rd = use_rv_ff ? use_q : '0;

   // second check stage
   assign cur_av     = room(e_ceil_ff, e_used_ff);
   assign cur_fail   = (cmd_ff == CMD_RESERVE) ? ((e_s_ff != '0) && (e_s_ff > cur_av))
                                               : e_cmp_ff;
   assign scan_last  = e_v_ff && (e_idx_ff == LAST_IDX);
   assign apply_last = rd_v_ff && (rd_idx_ff == LAST_IDX);
   assign go_apply   = (cmd_ff == CMD_RESERVE)
                       ? ((scope_ff <= SCOPE_MAX) && any_ff && !fail_seen_ff)
                       : !fail_seen_ff;
   assign bud_ceil   = ceiling(bud_rd.limit, data_ff ? bud_rd.reserve : '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_chan.cmd)
                  CMD_STAGE, CMD_LOAD, CMD_QUERY: state_in = req_dim_ok ? S_READ : S_RESP;
                  CMD_RESERVE, CMD_COMMIT, CMD_ROLLBACK, CMD_RELEASE: state_in = S_SCAN;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_READ:   state_in = S_SINGLE;
         S_SINGLE: state_in = S_RESP;
         S_SCAN:   if (scan_last) state_in = S_DECIDE;
         S_DECIDE: state_in = go_apply ? S_APPLY : S_RESP;
         S_APPLY:  if (apply_last) state_in = S_RESP;
         S_RESP:   if (rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in = cmd_ff;  dim_in = dim_ff;  amount_in = amount_ff;  resv_in = resv_ff;
      data_in = data_ff;  scope_in = scope_ff;
      status_in = status_ff;  any_in = any_ff;  fail_seen_in = fail_seen_ff;
      fail_idx_in = fail_idx_ff;  fail_req_in = fail_req_ff;  fail_av_in = fail_av_ff;
      hd_in = hd_ff;  hc_in = hc_ff;  qc_in = qc_ff;  qp_in = qp_ff;
      issue_idx_in = issue_idx_ff;  issue_done_in = issue_done_ff;
      rd_v_in = 1'b0;  rd_idx_in = rd_idx_ff;
      e_v_in = 1'b0;  e_idx_in = rd_idx_ff;
      e_s_in = bud_rd.staged;
      e_ceil_in = bud_ceil;
      e_used_in = sat_add(use_rd.committed, use_rd.pending);
      e_cmp_in = (cmd_ff == CMD_RELEASE) ? (bud_rd.staged > use_rd.committed)
                                         : (bud_rd.staged > use_rd.pending);
      bud_vld_in = bud_vld_ff;  use_vld_in = use_vld_ff;
      bud_rv_in = (int'(ram_raddr) < NDIM) && bud_vld_ff[ram_raddr];
      use_rv_in = (int'(ram_raddr) < NDIM) && use_vld_ff[ram_raddr];
      acc_in = acc_ff;  rej_in = rej_ff;  seq_in = seq_ff;
      bud_we = 1'b0;  bud_waddr = dim_idx;  bud_wdata = bud_rd;
      use_we = 1'b0;  use_waddr = rd_idx_ff;  use_wdata = use_rd;
      rsp_v_in = rsp_v_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;  rsp_fdim_in = rsp_fdim_ff;
      rsp_req_in = rsp_req_ff;  rsp_av_in = rsp_av_ff;
      rsp_hd_in = rsp_hd_ff;  rsp_hc_in = rsp_hc_ff;  rsp_qc_in = rsp_qc_ff;
      rsp_qp_in = rsp_qp_ff;  rsp_acc_in = rsp_acc_ff;  rsp_rej_in = rsp_rej_ff;
      rsp_seq_in = rsp_seq_ff;

      // walk address issue
      if ((state_ff == S_SCAN || state_ff == S_APPLY) && !issue_done_ff) begin
         rd_v_in   = 1'b1;
         rd_idx_in = issue_idx_ff;
         if (issue_idx_ff == LAST_IDX) begin
            issue_done_in = 1'b1;
         end else begin
            issue_idx_in = issue_idx_ff + IDX_W'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_chan.cmd;  dim_in = req_chan.dimension;
               amount_in = req_chan.amount;  resv_in = req_chan.reserve_amount;
               data_in = req_chan.data_class;  scope_in = req_chan.scope;
               any_in = 1'b0;  fail_seen_in = 1'b0;
               hd_in = '0;  hc_in = '0;  qc_in = '0;  qp_in = '0;
               issue_idx_in = '0;  issue_done_in = 1'b0;
               case (req_chan.cmd)
                  CMD_STAGE, CMD_LOAD, CMD_QUERY:
                     status_in = req_dim_ok ? ST_OK : ST_INVALID;
                  CMD_RESERVE, CMD_COMMIT, CMD_ROLLBACK, CMD_RELEASE:
                     status_in = ST_OK;
                  default: status_in = ST_INVALID;
               endcase
            end
         end
         // single-entry read-modify-write or query
         S_SINGLE: begin
            case (cmd_ff)
               CMD_STAGE: begin
                  bud_we = 1'b1;
                  bud_wdata.staged = amount_ff;
               end
               CMD_LOAD: begin
                  if (resv_ff > amount_ff) begin
                     status_in = ST_INVALID;
                  end else begin
                     bud_we = 1'b1;
                     bud_wdata.limit = amount_ff;
                     bud_wdata.reserve = resv_ff;
                  end
               end
               CMD_QUERY: begin
                  hd_in = room(ceiling(bud_rd.limit, bud_rd.reserve),
                               sat_add(use_rd.committed, use_rd.pending));
                  hc_in = room(bud_rd.limit, sat_add(use_rd.committed, use_rd.pending));
                  qc_in = use_rd.committed;
                  qp_in = use_rd.pending;
               end
               default: status_in = ST_INVALID;
            endcase
            if (bud_we && dim_ok) begin
               bud_vld_in[dim_idx] = 1'b1;
            end
         end
         // check walk, two stages after the read
         S_SCAN: begin
            e_v_in = rd_v_ff;
            if (e_v_ff) begin
               any_in = any_ff || (e_s_ff != '0);
               if (cur_fail && !fail_seen_ff) begin
                  fail_seen_in = 1'b1;
                  fail_idx_in  = e_idx_ff;
                  fail_req_in  = e_s_ff;
                  fail_av_in   = cur_av;
               end
            end
         end
         S_DECIDE: begin
            issue_idx_in = '0;
            issue_done_in = 1'b0;
            if (cmd_ff == CMD_RESERVE) begin
               if (scope_ff > SCOPE_MAX || !any_ff) begin
                  status_in = ST_INVALID;
               end else if (fail_seen_ff) begin
                  status_in = ST_EXHAUSTED;
                  rej_in = sat_inc(rej_ff);
                  seq_in = sat_inc(seq_ff);
               end
            end else if (fail_seen_ff) begin
               status_in = ST_INCONSISTENT;
            end
         end
         // update walk of the usage table
         S_APPLY: begin
            if (rd_v_ff) begin
               use_we = 1'b1;
               use_vld_in[rd_idx_ff] = 1'b1;
               case (cmd_ff)
                  CMD_RESERVE: use_wdata.pending = sat_add(use_rd.pending, bud_rd.staged);
                  CMD_COMMIT: begin
                     use_wdata.pending = use_rd.pending - bud_rd.staged;
                     use_wdata.committed = sat_add(use_rd.committed, bud_rd.staged);
                  end
                  CMD_ROLLBACK: use_wdata.pending = use_rd.pending - bud_rd.staged;
                  CMD_RELEASE: use_wdata.committed = use_rd.committed - bud_rd.staged;
                  default: use_we = 1'b0;
               endcase
            end
            if (apply_last) begin
               seq_in = sat_inc(seq_ff);
               if (cmd_ff == CMD_RESERVE) begin
                  acc_in = sat_inc(acc_ff);
               end
            end
         end
         // load response register
         S_RESP: begin
            if (rsp_free) begin
               rsp_v_in      = 1'b1;
               rsp_status_in = status_ff;
               rsp_fdim_in   = (status_ff == ST_EXHAUSTED) ? DIM_W'(fail_idx_ff) : '0;
               rsp_req_in    = (status_ff == ST_EXHAUSTED) ? fail_req_ff : '0;
               rsp_av_in     = (status_ff == ST_EXHAUSTED) ? fail_av_ff : '0;
               rsp_hd_in     = hd_ff;
               rsp_hc_in     = hc_ff;
               rsp_qc_in     = qc_ff;
               rsp_qp_in     = qp_ff;
               rsp_acc_in    = acc_ff;
               rsp_rej_in    = rej_ff;
               rsp_seq_in    = seq_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_idx_ff  <= '0;
         issue_done_ff <= 1'b0;
         rd_v_ff       <= 1'b0;
         e_v_ff        <= 1'b0;
         bud_vld_ff    <= '0;
         use_vld_ff    <= '0;
         bud_rv_ff     <= 1'b0;
         use_rv_ff     <= 1'b0;
         acc_ff        <= '0;
         rej_ff        <= '0;
         seq_ff        <= '0;
         rsp_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_idx_ff  <= issue_idx_in;
         issue_done_ff <= issue_done_in;
         rd_v_ff       <= rd_v_in;
         e_v_ff        <= e_v_in;
         bud_vld_ff    <= bud_vld_in;
         use_vld_ff    <= use_vld_in;
         bud_rv_ff     <= bud_rv_in;
         use_rv_ff     <= use_rv_in;
         acc_ff        <= acc_in;
         rej_ff        <= rej_in;
         seq_ff        <= seq_in;
         rsp_v_ff      <= rsp_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  dim_ff <= dim_in;  amount_ff <= amount_in;  resv_ff <= resv_in;
      data_ff <= data_in;  scope_ff <= scope_in;
      status_ff <= status_in;  any_ff <= any_in;  fail_seen_ff <= fail_seen_in;
      fail_idx_ff <= fail_idx_in;  fail_req_ff <= fail_req_in;  fail_av_ff <= fail_av_in;
      hd_ff <= hd_in;  hc_ff <= hc_in;  qc_ff <= qc_in;  qp_ff <= qp_in;
      rd_idx_ff <= rd_idx_in;  e_idx_ff <= e_idx_in;  e_s_ff <= e_s_in;
      e_ceil_ff <= e_ceil_in;  e_used_ff <= e_used_in;  e_cmp_ff <= e_cmp_in;
      rsp_status_ff <= rsp_status_in;  rsp_fdim_ff <= rsp_fdim_in;
      rsp_req_ff <= rsp_req_in;  rsp_av_ff <= rsp_av_in;
      rsp_hd_ff <= rsp_hd_in;  rsp_hc_ff <= rsp_hc_in;
      rsp_qc_ff <= rsp_qc_in;  rsp_qp_ff <= rsp_qp_in;
      rsp_acc_ff <= rsp_acc_in;  rsp_rej_ff <= rsp_rej_in;  rsp_seq_ff <= rsp_seq_in;
   end

   // response channel
   assign rsp_chan.valid            = rsp_v_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.fail_dimension   = rsp_fdim_ff;
   assign rsp_chan.requested        = rsp_req_ff;
   assign rsp_chan.available        = rsp_av_ff;
   assign rsp_chan.headroom_data    = rsp_hd_ff;
   assign rsp_chan.headroom_control = rsp_hc_ff;
   assign rsp_chan.committed_value  = rsp_qc_ff;
   assign rsp_chan.pending_value    = rsp_qp_ff;
   assign rsp_chan.accepted_count   = rsp_acc_ff;
   assign rsp_chan.rejected_count   = rsp_rej_ff;
   assign rsp_chan.event_count      = rsp_seq_ff;

   // no update walk after a failed check
   a_apply_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> !fail_seen_ff)
      else $error("update walk entered after a failed check");

   // the usage table is written only during the update walk
   a_use_write: assert property (@(posedge clock) disable iff (reset)
      use_we |-> (state_ff == S_APPLY))
      else $error("usage ram written outside the update walk");

   // the event counter never moves backward
   a_seq_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (seq_ff >= $past(seq_ff)))
      else $error("event counter decreased");

endmodule

`default_nettype wire

@@ verif/mrac_tb_if_note.sv @@
// testbench support: scoreboard class for admission control transactions
`timescale 1ns / 1ps

package mrac_tb_pkg;
   import mrac_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic [4:0]  fail_dimension;
      logic [63:0] requested;
      logic [63:0] available;
      logic [63:0] headroom_data;
      logic [63:0] headroom_control;
      logic [63:0] committed_value;
      logic [63:0] pending_value;
      logic [63:0] accepted_count;
      logic [63:0] rejected_count;
      logic [63:0] event_count;
   } outcome_type;

   class admission_scoreboard_type;
      logic [63:0] limits [NDIM];
      logic [63:0] reserves [NDIM];
      logic [63:0] committed [NDIM];
      logic [63:0] pending [NDIM];
      logic [63:0] staged [NDIM];
      logic [63:0] accepted_total, rejected_total, sequence_total;
      outcome_type awaited [$];
      int          mismatches;

      function new();
         for (int d = 0; d < NDIM; d++) begin
            limits[d] = 0; reserves[d] = 0; committed[d] = 0;
            pending[d] = 0; staged[d] = 0;
         end
         accepted_total = 0; rejected_total = 0; sequence_total = 0;
         mismatches = 0;
      endfunction

      function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
         logic [64:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[64] ? '1 : s[63:0];
      endfunction

      function logic [63:0] bump(logic [63:0] v);
         return (v == '1) ? v : v + 64'd1;
      endfunction

      function logic [63:0] top_of(int d, bit data);
         logic [63:0] r;
         r = data ? reserves[d] : 64'd0;
         return (limits[d] >= r) ? limits[d] - r : 64'd0;
      endfunction

      function logic [63:0] free_in(int d, bit data);
         logic [63:0] c;
         c = top_of(d, data);
         if (committed[d] >= c || pending[d] >= c - committed[d]) return 64'd0;
         return c - committed[d] - pending[d];
      endfunction

      function logic [63:0] room_for(int d, bit data);
         logic [63:0] c, u;
         c = top_of(d, data);
         u = add_sat(committed[d], pending[d]);
         return (u >= c) ? 64'd0 : c - u;
      endfunction

      // predict one accepted request transaction
      function void note_request(logic [2:0] cmd, logic [4:0] dim, logic [63:0] amount,
                                 logic [63:0] resv, bit data, logic [2:0] scope);
         outcome_type o;
         bit          dim_ok, any, fits;
         int          di;
         o = '{default: 0};
         dim_ok = int'(dim) < NDIM;
         di = dim_ok ? int'(dim) : 0;
         o.status = ST_OK;
         case (cmd)
            CMD_STAGE: begin
               if (!dim_ok) o.status = ST_INVALID;
               else staged[di] = amount;
            end
            CMD_RESERVE: begin
               any = 0;
               for (int d = 0; d < NDIM; d++) if (staged[d] != 0) any = 1;
               if (scope > SCOPE_MAX || !any) o.status = ST_INVALID;
               else begin
                  for (int d = 0; d < NDIM; d++) begin
                     if (o.status == ST_OK && staged[d] != 0 && staged[d] > free_in(d, data))
                     begin
                        o.status = ST_EXHAUSTED;
                        o.fail_dimension = 5'(d);
                        o.requested = staged[d];
                        o.available = free_in(d, data);
                     end
                  end
                  if (o.status == ST_OK) begin
                     for (int d = 0; d < NDIM; d++) pending[d] = add_sat(pending[d], staged[d]);
                     accepted_total = bump(accepted_total);
                  end else rejected_total = bump(rejected_total);
                  sequence_total = bump(sequence_total);
               end
            end
            CMD_COMMIT, CMD_ROLLBACK: begin
               fits = 1;
               for (int d = 0; d < NDIM; d++) if (staged[d] > pending[d]) fits = 0;
               if (!fits) o.status = ST_INCONSISTENT;
               else begin
                  for (int d = 0; d < NDIM; d++) begin
                     pending[d] = pending[d] - staged[d];
                     if (cmd == CMD_COMMIT) committed[d] = add_sat(committed[d], staged[d]);
                  end
                  sequence_total = bump(sequence_total);
               end
            end
            CMD_RELEASE: begin
               fits = 1;
               for (int d = 0; d < NDIM; d++) if (staged[d] > committed[d]) fits = 0;
               if (!fits) o.status = ST_INCONSISTENT;
               else begin
                  for (int d = 0; d < NDIM; d++) committed[d] = committed[d] - staged[d];
                  sequence_total = bump(sequence_total);
               end
            end
            CMD_LOAD: begin
               if (!dim_ok || resv > amount) o.status = ST_INVALID;
               else begin
                  limits[di] = amount;
                  reserves[di] = resv;
               end
            end
            CMD_QUERY: begin
               if (!dim_ok) o.status = ST_INVALID;
               else begin
                  o.headroom_data = room_for(di, 1);
                  o.headroom_control = room_for(di, 0);
                  o.committed_value = committed[di];
                  o.pending_value = pending[di];
               end
            end
            default: o.status = ST_INVALID;
         endcase
         o.accepted_count = accepted_total;
         o.rejected_count = rejected_total;
         o.event_count = sequence_total;
         awaited.push_back(o);
      endfunction

      // print one mismatch line and count it
      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %h expected %h", what, got, want);
         mismatches++;
      endtask

      // compare one response transaction against the oldest prediction
      task check_response(outcome_type got);
         outcome_type w;
         if (awaited.size() == 0) begin
            report("response with nothing outstanding", 64'd1, 64'd0);
            return;
         end
         w = awaited.pop_front();
         if (got.status !== w.status) report("status", 64'(got.status), 64'(w.status));
         if (got.fail_dimension !== w.fail_dimension)
            report("fail_dimension", 64'(got.fail_dimension), 64'(w.fail_dimension));
         if (got.requested !== w.requested) report("requested", got.requested, w.requested);
         if (got.available !== w.available) report("available", got.available, w.available);
         if (got.headroom_data !== w.headroom_data)
            report("headroom_data", got.headroom_data, w.headroom_data);
         if (got.headroom_control !== w.headroom_control)
            report("headroom_control", got.headroom_control, w.headroom_control);
         if (got.committed_value !== w.committed_value)
            report("committed_value", got.committed_value, w.committed_value);
         if (got.pending_value !== w.pending_value)
            report("pending_value", got.pending_value, w.pending_value);
         if (got.accepted_count !== w.accepted_count)
            report("accepted_count", got.accepted_count, w.accepted_count);
         if (got.rejected_count !== w.rejected_count)
            report("rejected_count", got.rejected_count, w.rejected_count);
         if (got.event_count !== w.event_count)
            report("event_count", got.event_count, w.event_count);
      endtask
   endclass
endpackage

@@ verif/tb_multi_resource_admission_control_unit.sv @@
// testbench top: drives requests, stalls responses and checks against a scoreboard
`timescale 1ns / 1ps

module tb_multi_resource_admission_control_unit;
   import mrac_pkg::*;
   import mrac_tb_pkg::*;

   localparam logic [2:0] CMD_UNKNOWN = 3'd7;

   logic clock = 0;
   logic reset = 1;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_off = 0;
   int   n_sent = 0;
   bit   stall_go = 0;
   bit   stall_used = 0;
   bit   stim_done = 0;

   mrac_req_if req_chan ();
   mrac_rsp_if rsp_chan ();

   admission_scoreboard_type ledger = new();

   multi_resource_admission_control_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // clock
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // receiver: random stalls plus one long hold-off counted here
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 0;
      else if (stall_go && !stall_used) begin
         stall_used <= 1;
         hold_off <= 400;
         rsp_chan.ready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_chan.ready <= 0;
      end else rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // response monitor
   always @(posedge clock) begin
      outcome_type o;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         o.status = rsp_chan.status;
         o.fail_dimension = rsp_chan.fail_dimension;
         o.requested = rsp_chan.requested;
         o.available = rsp_chan.available;
         o.headroom_data = rsp_chan.headroom_data;
         o.headroom_control = rsp_chan.headroom_control;
         o.committed_value = rsp_chan.committed_value;
         o.pending_value = rsp_chan.pending_value;
         o.accepted_count = rsp_chan.accepted_count;
         o.rejected_count = rsp_chan.rejected_count;
         o.event_count = rsp_chan.event_count;
         ledger.check_response(o);
      end
   end

   // offer one request transaction and wait for it to be taken
   task automatic send(logic [2:0] cmd, logic [4:0] dim, logic [63:0] amount,
                       logic [63:0] resv, bit data, logic [2:0] scope);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.cmd <= cmd;
      req_chan.dimension <= dim;
      req_chan.amount <= amount;
      req_chan.reserve_amount <= resv;
      req_chan.data_class <= data;
      req_chan.scope <= scope;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      ledger.note_request(cmd, dim, amount, resv, data, scope);
      n_sent++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // amount biased toward small, with occasional extremes
   function automatic logic [63:0] pick_amount();
      case ($urandom_range(9))
         0: return '1;
         1: return rand64();
         2: return 64'd0;
         default: return 64'($urandom_range(60));
      endcase
   endfunction

   // one well-formed reservation cycle with random content
   task automatic lifecycle();
      int n;
      n = $urandom_range(1, 3);
      for (int k = 0; k < NDIM; k++)
         if ($urandom_range(3) == 0) send(CMD_STAGE, 5'(k), 0, 0, 0, 0);
      repeat (n) send(CMD_STAGE, 5'($urandom_range(NDIM - 1)), 64'($urandom_range(1, 30)),
                      0, 0, 0);
      send(CMD_RESERVE, 0, 0, 0, 1'($urandom_range(1)), 3'($urandom_range(6)));
      case ($urandom_range(2))
         0: begin
            send(CMD_COMMIT, 0, 0, 0, 0, 0);
            send(CMD_QUERY, 5'($urandom_range(NDIM - 1)), 0, 0, 0, 0);
            if ($urandom_range(1)) send(CMD_RELEASE, 0, 0, 0, 0, 0);
         end
         1: send(CMD_ROLLBACK, 0, 0, 0, 0, 0);
         default: send(CMD_QUERY, 5'($urandom_range(NDIM - 1)), 0, 0, 0, 0);
      endcase
   endtask

   task automatic noise();
      logic [63:0] a;
      a = pick_amount();
      send(3'($urandom_range(7)), 5'($urandom_range(31)), a,
           $urandom_range(1) ? pick_amount() : (a >> $urandom_range(3)),
           1'($urandom_range(1)), 3'($urandom_range(7)));
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_chan.valid <= 0;
      while (ledger.awaited.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int phase_base;
      req_chan.valid <= 0;
      req_chan.cmd <= CMD_STAGE;
      req_chan.dimension <= 0;
      req_chan.amount <= 0;
      req_chan.reserve_amount <= 0;
      req_chan.data_class <= 0;
      req_chan.scope <= 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every command and the special cases
      send(CMD_RESERVE, 0, 0, 0, 0, 0);                 // all-zero staged vector
      send(CMD_QUERY, 0, 0, 0, 0, 0);
      send(CMD_LOAD, 0, 100, 40, 0, 0);
      send(CMD_LOAD, 5'(NDIM - 1), '1, '1, 0, 0);
      send(CMD_LOAD, 1, 10, 11, 0, 0);                  // reserve above limit
      send(CMD_LOAD, 31, 5, 0, 0, 0);                   // dimension out of range
      send(CMD_STAGE, 31, 5, 0, 0, 0);
      send(CMD_QUERY, 5'(NDIM), 0, 0, 0, 0);
      send(CMD_STAGE, 0, 70, 0, 0, 0);
      send(CMD_RESERVE, 0, 0, 0, 1, 7);                 // invalid scope
      send(CMD_RESERVE, 0, 0, 0, 1, 6);                 // data plane blocked by reserve
      send(CMD_RESERVE, 0, 0, 0, 0, 0);                 // control plane uses the reserve
      send(CMD_QUERY, 0, 0, 0, 0, 0);
      send(CMD_COMMIT, 0, 0, 0, 0, 0);
      send(CMD_COMMIT, 0, 0, 0, 0, 0);                  // pending underflow
      send(CMD_RELEASE, 0, 0, 0, 0, 0);
      send(CMD_RELEASE, 0, 0, 0, 0, 0);                 // committed underflow
      send(CMD_ROLLBACK, 0, 0, 0, 0, 0);
      send(CMD_STAGE, 0, 0, 0, 0, 0);
      send(CMD_STAGE, 5'(NDIM - 1), '1, 0, 0, 0);
      send(CMD_RESERVE, 0, 0, 0, 0, 3);                 // saturating pending
      send(CMD_RESERVE, 0, 0, 0, 0, 3);
      send(CMD_QUERY, 5'(NDIM - 1), 0, 0, 0, 0);
      send(CMD_UNKNOWN, 0, 0, 0, 0, 0);                 // unknown command
      send(CMD_STAGE, 5'(NDIM - 1), 0, 0, 0, 0);
      drain();

      // generous budgets so reservations mostly succeed
      for (int d = 0; d < NDIM; d++)
         send(CMD_LOAD, 5'(d), 64'($urandom_range(40, 400)), 64'($urandom_range(0, 30)), 0, 0);

      // three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 66 : 0;
         recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 21 : 0;
         phase_base = n_sent;
         if (ph == 2) stall_go = 1;
         while (n_sent - phase_base < 235) begin
            if ($urandom_range(4) != 0) lifecycle();
            else noise();
            if ($urandom_range(40) == 0)
               send(CMD_LOAD, 5'($urandom_range(NDIM - 1)), 64'($urandom_range(20, 400)),
                    64'($urandom_range(30)), 0, 0);
         end
      end
      drain();
      stim_done = 1;
   end

   // end of run
   initial begin
      wait (stim_done);
      if (ledger.mismatches == 0 && ledger.awaited.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // timeout
   initial begin
      #80ms;
      $display("simulation failed");
      $finish;
   end
endmodule
